@@ src/hbm_pkg.sv @@
// Shared types, constants and the 64-bit population count for the Hamming matcher.
// Used by hbm_lane, hbm_merge and hamming_best_two_ratio_matcher; depends on nothing.
package hbm_pkg;

    localparam int WORD_W        = 64;
    localparam int LANES         = 4;
    localparam int CNT_W         = 7;
    localparam int DIST_W        = 9;
    localparam int RATIO_W       = 9;
    localparam int INDEX_FIELD_W = 12;
    localparam int INDEX_BITS_DEFAULT = 12;
    localparam int CFG_IDX_W     = 8;

    localparam int IN_TDATA_W  = 280;
    localparam int OUT_TDATA_W = 32;

    localparam logic [DIST_W-1:0]  NONE_DIST     = 9'd257;
    localparam logic [DIST_W-1:0]  THRESHOLD_RST = 9'd50;
    localparam logic [RATIO_W-1:0] RATIO_RST     = 9'd154;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_Q8        = 8'd1;

    localparam logic MODE_QUERY = 1'b0;
    localparam logic MODE_CAND  = 1'b1;

    localparam logic [WORD_W-1:0] PC_M1 = 64'h5555_5555_5555_5555;
    localparam logic [WORD_W-1:0] PC_M2 = 64'h3333_3333_3333_3333;
    localparam logic [WORD_W-1:0] PC_M4 = 64'h0F0F_0F0F_0F0F_0F0F;

    typedef struct packed {
        logic              mode;
        logic              last;
        logic [DIST_W-1:0] prior;
    } ctl_t;

    typedef struct packed {
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] second;
    } res_t;

    // Bit-sliced population count; the low byte of the final fold holds the total.
    function automatic logic [CNT_W-1:0] popcount64(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        a = v - ((v >> 1) & PC_M1);
        b = (a & PC_M2) + ((a >> 2) & PC_M2);
        c = (b + (b >> 4)) & PC_M4;
        d = c + (c >> 8);
        d = d + (d >> 16);
        d = d + (d >> 32);
        return d[CNT_W-1:0];
    endfunction

endpackage

@@ src/hbm_lane.sv @@
// One distance lane: XOR of a 64-bit query word with a candidate word and a registered popcount.
// Depends on hbm_pkg.
module hbm_lane (
    input  logic                        clk,
    input  logic                        en,
    input  logic [hbm_pkg::WORD_W-1:0]  query_word,
    input  logic [hbm_pkg::WORD_W-1:0]  cand_word,
    output logic [hbm_pkg::CNT_W-1:0]   count
);
    import hbm_pkg::*;

    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            count_reg <= popcount64(query_word ^ cand_word);
        end
    end

    assign count = count_reg;

endmodule

@@ src/hbm_merge.sv @@
// Merging stage: sums the lane counts, keeps the best and second-best trackers and holds
// one finished result. Depends on hbm_pkg.
module hbm_merge #(
    parameter int INDEX_BITS = hbm_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  hbm_pkg::ctl_t              in_ctl,
    input  logic [INDEX_BITS-1:0]      in_idx,
    input  logic [hbm_pkg::CNT_W-1:0]  lane_count [hbm_pkg::LANES],
    output logic                       out_valid,
    input  logic                       out_ready,
    output hbm_pkg::res_t              out_res,
    output logic [INDEX_BITS-1:0]      out_idx
);
    import hbm_pkg::*;

    logic                  s2_valid_reg;
    logic                  s2_valid_next;
    ctl_t                  s2_ctl_reg;
    logic [INDEX_BITS-1:0] s2_idx_reg;
    logic [DIST_W-1:0]     s2_dist_reg;
    logic [DIST_W-1:0]     dist_sum;

    logic [DIST_W-1:0]     best_reg;
    logic [DIST_W-1:0]     best_next;
    logic [DIST_W-1:0]     second_reg;
    logic [DIST_W-1:0]     second_next;
    logic [INDEX_BITS-1:0] bidx_reg;
    logic [INDEX_BITS-1:0] bidx_next;

    logic [DIST_W-1:0]     upd_best;
    logic [DIST_W-1:0]     upd_second;
    logic [INDEX_BITS-1:0] upd_idx;

    logic                  r_valid_reg;
    logic                  r_valid_next;
    res_t                  r_res_reg;
    logic [INDEX_BITS-1:0] r_idx_reg;

    logic s2_emits;
    logic s2_go;
    logic r_free;
    logic in_take;

    assign r_free   = !r_valid_reg || out_ready;
    assign s2_emits = (s2_ctl_reg.mode == MODE_CAND) && s2_ctl_reg.last;
    assign s2_go    = s2_valid_reg && (!s2_emits || r_free);
    assign in_ready = !s2_valid_reg || s2_go;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        dist_sum = '0;
        for (int l = 0; l < LANES; l++)
        begin
            dist_sum = dist_sum + DIST_W'(lane_count[l]);
        end
    end

    always_comb
    begin
        upd_best   = best_reg;
        upd_second = second_reg;
        upd_idx    = bidx_reg;
        if (s2_ctl_reg.prior > s2_dist_reg)
        begin
            if (s2_dist_reg < best_reg)
            begin
                upd_second = best_reg;
                upd_best   = s2_dist_reg;
                upd_idx    = s2_idx_reg;
            end
            else if (s2_dist_reg < second_reg)
            begin
                upd_second = s2_dist_reg;
            end
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (in_take)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_go)
        begin
            s2_valid_next = 1'b0;
        end

        best_next   = best_reg;
        second_next = second_reg;
        bidx_next   = bidx_reg;
        if (s2_go)
        begin
            if ((s2_ctl_reg.mode == MODE_QUERY) || s2_ctl_reg.last)
            begin
                best_next   = NONE_DIST;
                second_next = NONE_DIST;
                bidx_next   = '0;
            end
            else
            begin
                best_next   = upd_best;
                second_next = upd_second;
                bidx_next   = upd_idx;
            end
        end

        r_valid_next = r_valid_reg;
        if (s2_go && s2_emits)
        begin
            r_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            r_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            best_reg     <= NONE_DIST;
            second_reg   <= NONE_DIST;
            bidx_reg     <= '0;
            r_valid_reg  <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            best_reg     <= best_next;
            second_reg   <= second_next;
            bidx_reg     <= bidx_next;
            r_valid_reg  <= r_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s2_ctl_reg  <= in_ctl;
            s2_idx_reg  <= in_idx;
            s2_dist_reg <= dist_sum;
        end
        if (s2_go && s2_emits)
        begin
            r_res_reg.best   <= upd_best;
            r_res_reg.second <= upd_second;
            r_idx_reg        <= upd_idx;
        end
    end

    assign out_valid = r_valid_reg;
    assign out_res   = r_res_reg;
    assign out_idx   = r_idx_reg;

endmodule

@@ src/hamming_best_two_ratio_matcher.sv @@
// Top level of the Hamming best-two ratio matcher: input stage, four popcount lanes,
// the merging stage and the ratio-test output register. Depends on hbm_pkg, hbm_lane, hbm_merge.
//
// A query transaction (tuser mode 0) loads the 256-bit query descriptor and clears the
// best and second-best trackers. Candidate transactions (mode 1) carry a descriptor, an
// index and a prior distance; tlast marks the final candidate of a search, and only that
// transaction yields one result transaction on the output channel.
// Configuration writes on the cfg channel are always taken: index 0 is the match
// threshold, index 1 the ratio limit in units of 1/256; other indexes are ignored.
// Throughput is one input transaction per clock while the receiver does not stall. After the
// last candidate is accepted, the popcount lanes register its counts, the tracker stage its
// distance sum, the result register the tracker update, and the ratio test the output register.
// When the receiver stalls, the output and result registers each hold a finished result
// and the tracker stage holds the next final candidate; other candidates keep flowing
// until then, and s_axis_tready drops once one more transaction waits in the input stage.
// Reset clears the query to zero, the trackers to no match, and the registers to a
// threshold of 50 and a ratio of 154.
module hamming_best_two_ratio_matcher #(
    parameter int INDEX_BITS = hbm_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // desc_word0, desc_word1, desc_word2, desc_word3, cand_index, prior_dist, zero fill
    input  logic [hbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // mode
    input  logic [0:0]                         s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // best_index, best_dist, second_dist, zero fill
    output logic [hbm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // matched
    output logic [0:0]                         m_axis_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hbm_pkg::DIST_W-1:0]         cfg_data
);
    import hbm_pkg::*;

    localparam int DESC_W    = WORD_W * LANES;
    localparam int IDX_LSB   = DESC_W;
    localparam int PRIOR_LSB = DESC_W + INDEX_FIELD_W;
    localparam int PROD_W    = DIST_W + RATIO_W;

    logic [DIST_W-1:0]  thr_reg;
    logic [RATIO_W-1:0] ratio_reg;

    logic [WORD_W-1:0]  query_reg [LANES];
    logic [WORD_W-1:0]  cand_words [LANES];
    logic [CNT_W-1:0]   lane_count [LANES];

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    ctl_t                  s1_ctl_reg;
    logic [INDEX_BITS-1:0] s1_idx_reg;
    ctl_t                  in_ctl;
    logic [INDEX_BITS-1:0] in_idx;
    logic                  s_accept;
    logic                  s2_ready;
    logic                  s1_free;

    logic                  r_valid;
    res_t                  r_res;
    logic [INDEX_BITS-1:0] r_idx;
    logic                  o_free;
    logic                  r_take;

    logic                  o_valid_reg;
    logic                  o_valid_next;
    logic                  o_matched_reg;
    res_t                  o_res_reg;
    logic [INDEX_BITS-1:0] o_idx_reg;
    logic                  matched_calc;
    logic [PROD_W-1:0]     lhs_prod;
    logic [PROD_W-1:0]     rhs_prod;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THRESHOLD_RST;
            ratio_reg <= RATIO_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MATCH_THRESHOLD: thr_reg   <= cfg_data;
                REG_RATIO_Q8:        ratio_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign in_ctl.mode  = s_axis_tuser[0];
    assign in_ctl.last  = s_axis_tlast;
    assign in_ctl.prior = s_axis_tdata[PRIOR_LSB +: DIST_W];
    assign in_idx       = INDEX_BITS'(s_axis_tdata[IDX_LSB +: INDEX_FIELD_W]);

    assign s1_free       = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_free;
    assign s_accept      = s_axis_tvalid && s1_free;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            for (int l = 0; l < LANES; l++)
            begin
                query_reg[l] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s_accept && (in_ctl.mode == MODE_QUERY))
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    query_reg[l] <= s_axis_tdata[l*WORD_W +: WORD_W];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_ctl_reg <= in_ctl;
            s1_idx_reg <= in_idx;
        end
    end

    genvar gl;
    generate
        for (gl = 0; gl < LANES; gl++)
        begin : g_lane
            assign cand_words[gl] = s_axis_tdata[gl*WORD_W +: WORD_W];

            hbm_lane u_lane (
                .clk        (clk),
                .en         (s_accept),
                .query_word (query_reg[gl]),
                .cand_word  (cand_words[gl]),
                .count      (lane_count[gl])
            );
        end
    endgenerate

    hbm_merge #(
        .INDEX_BITS (INDEX_BITS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid_reg),
        .in_ready   (s2_ready),
        .in_ctl     (s1_ctl_reg),
        .in_idx     (s1_idx_reg),
        .lane_count (lane_count),
        .out_valid  (r_valid),
        .out_ready  (o_free),
        .out_res    (r_res),
        .out_idx    (r_idx)
    );

    assign o_free = !o_valid_reg || m_axis_tready;
    assign r_take = r_valid && o_free;

    assign lhs_prod = {1'b0, r_res.best, 8'b0};
    assign rhs_prod = PROD_W'(r_res.second) * PROD_W'(ratio_reg);

    always_comb
    begin
        matched_calc = (r_res.best != NONE_DIST) && (r_res.best <= thr_reg);
        if (r_res.second != NONE_DIST)
        begin
            matched_calc = matched_calc && (lhs_prod < rhs_prod);
        end
    end

    always_comb
    begin
        o_valid_next = o_valid_reg;
        if (r_take)
        begin
            o_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_take)
        begin
            o_matched_reg <= matched_calc;
            o_res_reg     <= r_res;
            o_idx_reg     <= r_idx;
        end
    end

    assign m_axis_tvalid   = o_valid_reg;
    assign m_axis_tuser[0] = o_matched_reg;
    assign m_axis_tdata    = OUT_TDATA_W'({o_res_reg.second, o_res_reg.best,
                                           INDEX_FIELD_W'(o_idx_reg)});

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && r_valid && o_valid_reg))
        else $error("input stalled while the pipeline had room");

    a_match_within_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_matched_reg) |-> (o_res_reg.best <= thr_reg))
        else $error("match reported above the threshold");

    a_match_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_matched_reg) |-> (o_res_reg.best != NONE_DIST))
        else $error("match reported without a best candidate");

    a_best_not_above_second: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> (o_res_reg.best <= o_res_reg.second))
        else $error("best distance exceeds second-best distance");

endmodule

@@ sim/hamming_best_two_ratio_matcher_test.sv @@
// Self-checking testbench for hamming_best_two_ratio_matcher: directed and random searches
// with random stalls on both streams, checked against a built-in predictor.
// Depends on hbm_pkg and the hamming_best_two_ratio_matcher RTL only.
`timescale 1ns / 1ps

module hamming_best_two_ratio_matcher_test;

    import hbm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_RATIO_Q8 + 8'd1;
    localparam int DESC_W = LANES * WORD_W;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 145;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD_CYCLES = 200;

    typedef struct packed {
        logic                           mode;
        logic                           last;
        logic [DIST_W-1:0]              prior;
        logic [INDEX_FIELD_W-1:0]       index;
        logic [LANES-1:0][WORD_W-1:0]   desc;
    } desc_item_t;

    typedef struct packed {
        logic                           matched;
        logic [INDEX_FIELD_W-1:0]       best_index;
        logic [DIST_W-1:0]              best_dist;
        logic [DIST_W-1:0]              second_dist;
    } match_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [IN_TDATA_W-1:0]        s_axis_tdata = '0;
    logic [0:0]                   s_axis_tuser = '0;
    logic                         s_axis_tlast = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]       m_axis_tdata;
    logic [0:0]                   m_axis_tuser;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [DIST_W-1:0]            cfg_data = '0;

    desc_item_t                   pending_items[$];
    match_result_t                predicted_matches[$];
    desc_item_t                   cur_item = '0;
    match_result_t                want;

    logic [DESC_W-1:0]            query_bits = '0;
    int                           best_d = int'(NONE_DIST);
    int                           second_d = int'(NONE_DIST);
    logic [INDEX_FIELD_W-1:0]     best_i = '0;
    int                           thr_limit = int'(THRESHOLD_RST);
    int                           ratio_limit = int'(RATIO_RST);

    logic [DESC_W-1:0]            gen_query = '0;
    logic                         in_taken = 1'b0;
    logic                         src_idle_on = 1'b1;
    logic                         sink_idle_on = 1'b1;
    int                           src_wait = 0;
    int                           sink_stall = 0;
    int                           hold_left = 0;
    int                           hold_requests = 0;
    int                           holds_served = 0;
    int                           queued_count = 0;
    int                           accepted_count = 0;
    int                           cfg_writes = 0;
    int                           results_predicted = 0;
    int                           results_checked = 0;
    int                           matched_count = 0;
    int                           mismatches = 0;
    int                           settings_count = 1;

    hamming_best_two_ratio_matcher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DESC_W-1:0] rand_desc();
        logic [DESC_W-1:0] v;
        for (int k = 0; k < DESC_W / 32; k++)
        begin
            v[k*32 +: 32] = $urandom();
        end
        return v;
    endfunction

    function automatic logic [DESC_W-1:0] low_ones(int count);
        logic [DESC_W-1:0] v;
        v = '0;
        for (int k = 0; k < count; k++)
        begin
            v[k] = 1'b1;
        end
        return v;
    endfunction

    function automatic logic [DESC_W-1:0] flip_bits(logic [DESC_W-1:0] base, int count);
        logic [DESC_W-1:0] v;
        int                pos;
        v = base;
        for (int k = 0; k < count; k++)
        begin
            pos = $urandom_range(0, DESC_W - 1);
            v[pos] = ~v[pos];
        end
        return v;
    endfunction

    task automatic clear_search();
        best_d = int'(NONE_DIST);
        second_d = int'(NONE_DIST);
        best_i = '0;
    endtask

    task automatic score_item(input desc_item_t it);
        int            ham_d;
        logic          pass;
        match_result_t r;
        if (it.mode == MODE_QUERY)
        begin
            query_bits = it.desc;
            clear_search();
            return;
        end
        ham_d = $countones(query_bits ^ it.desc);
        if (int'(it.prior) > ham_d)
        begin
            if (ham_d < best_d)
            begin
                second_d = best_d;
                best_d = ham_d;
                best_i = it.index;
            end
            else if (ham_d < second_d)
            begin
                second_d = ham_d;
            end
        end
        if (!it.last)
        begin
            return;
        end
        pass = (best_d != int'(NONE_DIST)) && (best_d <= thr_limit);
        if (pass && second_d != int'(NONE_DIST))
        begin
            pass = (best_d * 256) < (second_d * ratio_limit);
        end
        r.matched = pass;
        r.best_index = best_i;
        r.best_dist = best_d[DIST_W-1:0];
        r.second_dist = second_d[DIST_W-1:0];
        predicted_matches = {predicted_matches, r};
        results_predicted++;
        clear_search();
    endtask

    always @(posedge clk)
    begin
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            accepted_count++;
            score_item(cur_item);
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MATCH_THRESHOLD: thr_limit = int'(cfg_data);
                REG_RATIO_Q8:        ratio_limit = int'(cfg_data);
                default:             ;
            endcase
            cfg_writes++;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || in_taken)
        begin
            if (src_wait > 0)
            begin
                src_wait--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                cur_item = pending_items.pop_front();
                s_axis_tdata <= {3'b000, cur_item.prior, cur_item.index, cur_item.desc};
                s_axis_tuser <= cur_item.mode;
                s_axis_tlast <= cur_item.last;
                s_axis_tvalid <= 1'b1;
                src_wait = (src_idle_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_stall > 0)
        begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (sink_idle_on && $urandom_range(0, 99) < 25)
            begin
                sink_stall = pick_gap();
            end
        end
    end

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (predicted_matches.size() == 0)
            begin
                $error("result transaction arrived with no expectation pending");
                mismatches++;
            end
            else
            begin
                want = predicted_matches.pop_front();
                results_checked++;
                if (want.matched)
                begin
                    matched_count++;
                end
                check_field("matched", int'(want.matched), int'(m_axis_tuser[0]));
                check_field("best_index", int'(want.best_index), int'(m_axis_tdata[11:0]));
                check_field("best_dist", int'(want.best_dist), int'(m_axis_tdata[20:12]));
                check_field("second_dist", int'(want.second_dist), int'(m_axis_tdata[29:21]));
            end
        end
    end

    task automatic push_item(input logic mode, input logic last, input int prior,
                             input int index, input logic [DESC_W-1:0] desc);
        desc_item_t it;
        it.mode = mode;
        it.last = last;
        it.prior = prior[DIST_W-1:0];
        it.index = index[INDEX_FIELD_W-1:0];
        it.desc = desc;
        pending_items = {pending_items, it};
        queued_count++;
    endtask

    function automatic int rand_prior();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            return int'(NONE_DIST);
        end
        if (roll < 85)
        begin
            return $urandom_range(0, 511);
        end
        return $urandom_range(0, 80);
    endfunction

    task automatic queue_search();
        int                count;
        int                roll;
        logic [DESC_W-1:0] d;
        if ($urandom_range(0, 9) != 0)
        begin
            gen_query = rand_desc();
            push_item(MODE_QUERY, 1'($urandom_range(0, 1)), $urandom_range(0, 511),
                      $urandom_range(0, 4095), gen_query);
        end
        count = $urandom_range(1, 8);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 4)
            begin
                gen_query = rand_desc();
                push_item(MODE_QUERY, 1'b0, rand_prior(), $urandom_range(0, 4095), gen_query);
            end
            roll = $urandom_range(0, 99);
            if (roll < 50)
            begin
                d = flip_bits(gen_query, $urandom_range(0, 60));
            end
            else if (roll < 80)
            begin
                d = flip_bits(gen_query, $urandom_range(40, 140));
            end
            else if (roll < 88)
            begin
                d = ($urandom_range(0, 1) != 0) ? gen_query : ~gen_query;
            end
            else
            begin
                d = rand_desc();
            end
            push_item(MODE_CAND, k == count - 1, rand_prior(), $urandom_range(0, 4095), d);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        int target;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[DIST_W-1:0];
        target = cfg_writes + 1;
        wait (cfg_writes == target);
    endtask

    task automatic drain();
        wait (accepted_count == queued_count && results_checked == results_predicted);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [DESC_W-1:0] qd;
        int                thr;
        int                ratio;
        int                phase_start;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_item(MODE_CAND, 1'b0, int'(NONE_DIST), 4095, '0);
        push_item(MODE_CAND, 1'b1, 511, 0, '1);
        push_item(MODE_QUERY, 1'b1, 0, 4095, '1);
        push_item(MODE_CAND, 1'b1, 0, 1, '1);
        qd = rand_desc();
        push_item(MODE_QUERY, 1'b0, int'(NONE_DIST), 0, qd);
        push_item(MODE_CAND, 1'b0, 300, 7, qd ^ low_ones(5));
        push_item(MODE_CAND, 1'b0, int'(NONE_DIST), 9, qd ^ low_ones(5));
        push_item(MODE_CAND, 1'b0, 6, 11, qd ^ low_ones(5));
        push_item(MODE_CAND, 1'b0, 3, 13, qd ^ low_ones(3));
        push_item(MODE_CAND, 1'b1, 4, 15, qd ^ low_ones(3));
        push_item(MODE_CAND, 1'b1, int'(NONE_DIST), 12'hAAA, qd ^ low_ones(50));
        push_item(MODE_CAND, 1'b1, int'(NONE_DIST), 12'h555, qd ^ low_ones(51));
        push_item(MODE_CAND, 1'b0, 256, 100, ~qd);
        push_item(MODE_CAND, 1'b0, int'(NONE_DIST), 101, ~qd);
        push_item(MODE_CAND, 1'b0, int'(NONE_DIST), 102, qd ^ low_ones(200));
        push_item(MODE_CAND, 1'b1, 11, 103, qd ^ low_ones(10));
        push_item(MODE_CAND, 1'b0, int'(NONE_DIST), 5, qd ^ low_ones(4));
        push_item(MODE_CAND, 1'b1, int'(NONE_DIST), 6, qd ^ low_ones(5));
        push_item(MODE_QUERY, 1'b0, 511, 4095, '0);
        push_item(MODE_CAND, 1'b1, int'(NONE_DIST), 4095, '0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    thr = 256;
                    ratio = 256;
                end
                1:
                begin
                    thr = 0;
                    ratio = 0;
                end
                2:
                begin
                    thr = 256;
                    ratio = 0;
                end
                3:
                begin
                    thr = 0;
                    ratio = 256;
                end
                4:
                begin
                    thr = int'(THRESHOLD_RST);
                    ratio = int'(RATIO_RST);
                end
                default:
                begin
                    thr = $urandom_range(0, 256);
                    ratio = $urandom_range(0, 256);
                end
            endcase
            write_reg(REG_MATCH_THRESHOLD, thr);
            write_reg(REG_RATIO_Q8, ratio);
            if (p == 1)
            begin
                write_reg(REG_UNUSED, $urandom_range(0, 511));
            end
            @(negedge clk);
            cfg_valid <= 1'b0;
            settings_count++;

            src_idle_on = (p % 3) != 1;
            sink_idle_on = (p % 3) != 2;
            if (p == 2)
            begin
                hold_requests++;
            end
            phase_start = queued_count;
            while (queued_count - phase_start < PHASE_ITEMS)
            begin
                queue_search();
            end
            drain();
        end

        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d input transactions under %0d register settings.",
                 accepted_count, settings_count);
        $display("%0d search results were checked, %0d of them reported a match.",
                 results_checked, matched_count);
        if (mismatches == 0 && predicted_matches.size() == 0)
        begin
            $display("hamming_best_two_ratio_matcher test passed");
        end
        else
        begin
            $display("hamming_best_two_ratio_matcher test failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("hamming_best_two_ratio_matcher test failed");
        $finish;
    end

endmodule
